### rtl/core/assert_macros.svh
// assertion macros shared by the set operation engine rtl
// no dependencies; included by modules that carry concurrent checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge outside reset
`define SSOE_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// implication whose consequent is checked in the cycle after the antecedent
`define SSOE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/ssoe_pkg.sv
// package for the set operation engine: codes, microcode word and program rom
// no dependencies; imported by small_set_operation_engine and the testbench
`timescale 1ns / 1ps
`default_nettype none

package ssoe_pkg;

    localparam int SET_SIZE_DEF = 16;
    localparam int DATA_W       = 32;

    // input kind codes
    localparam logic [1:0] KIND_A     = 2'd0;
    localparam logic [1:0] KIND_B     = 2'd1;
    localparam logic [1:0] KIND_QUERY = 2'd2;

    // operation register codes
    localparam logic [1:0] OPER_UNION = 2'd0;
    localparam logic [1:0] OPER_INTER = 2'd1;
    localparam logic [1:0] OPER_DIFF  = 2'd2;

    typedef logic [3:0] step_t;

    // program addresses
    localparam step_t ST_IDLE    = 4'd0;
    localparam step_t ST_INIT    = 4'd1;
    localparam step_t ST_OUTER   = 4'd2;
    localparam step_t ST_FETCH   = 4'd3;
    localparam step_t ST_SCAN    = 4'd4;
    localparam step_t ST_DECIDE  = 4'd5;
    localparam step_t ST_NEXT    = 4'd6;
    localparam step_t ST_ENDPASS = 4'd7;
    localparam step_t ST_FLUSH   = 4'd8;
    localparam step_t ST_QSTART  = 4'd9;
    localparam step_t ST_LAST    = ST_QSTART;

    // datapath action of one step
    typedef enum logic [3:0] {
        UOP_IDLE,
        UOP_INIT,
        UOP_ISSUE,
        UOP_FETCH,
        UOP_SCAN0,
        UOP_SCAN,
        UOP_DECIDE,
        UOP_NEXT,
        UOP_ENDPASS,
        UOP_FLUSH
    } uop_t;

    // jump condition of one step
    typedef enum logic [2:0] {
        COND_NEVER,
        COND_ALWAYS,
        COND_OUTER_DONE,
        COND_SCAN_MORE,
        COND_IS_QUERY,
        COND_TO_B
    } cond_t;

    typedef struct packed {
        uop_t  uop;
        cond_t cond;
        logic  stall;
        step_t target;
    } ctl_word_t;

    // microcode program: falls through to the next step when the condition is false
    function automatic ctl_word_t ucode_rom(input step_t s);
        ctl_word_t w;
        w = '{uop: UOP_IDLE, cond: COND_NEVER, stall: 1'b0, target: ST_IDLE};
        case (s)
            ST_IDLE:    w = '{UOP_IDLE,    COND_NEVER,      1'b0, ST_IDLE};
            ST_INIT:    w = '{UOP_INIT,    COND_NEVER,      1'b0, ST_IDLE};
            ST_OUTER:   w = '{UOP_ISSUE,   COND_OUTER_DONE, 1'b0, ST_ENDPASS};
            ST_FETCH:   w = '{UOP_FETCH,   COND_NEVER,      1'b0, ST_IDLE};
            ST_SCAN:    w = '{UOP_SCAN,    COND_SCAN_MORE,  1'b0, ST_SCAN};
            ST_DECIDE:  w = '{UOP_DECIDE,  COND_IS_QUERY,   1'b1, ST_IDLE};
            ST_NEXT:    w = '{UOP_NEXT,    COND_ALWAYS,     1'b0, ST_OUTER};
            ST_ENDPASS: w = '{UOP_ENDPASS, COND_TO_B,       1'b0, ST_OUTER};
            ST_FLUSH:   w = '{UOP_FLUSH,   COND_ALWAYS,     1'b1, ST_IDLE};
            ST_QSTART:  w = '{UOP_SCAN0,   COND_ALWAYS,     1'b0, ST_SCAN};
            default:    w = '{UOP_IDLE,    COND_ALWAYS,     1'b0, ST_IDLE};
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

### rtl/core/small_set_operation_engine.sv
// set union / intersection / difference engine with membership query
// microcoded sequencer over two set memories; depends on ssoe_pkg, assert_macros.svh
// usage:
//   s_ channel carries one item per transaction: tdata = value, tuser = kind
//   (0 set A element, 1 set B element, 2 query against A), tlast = last of set.
//   m_ channel returns results: tdata = element, tuser[0] = is_empty,
//   tuser[1] = found, tlast = last item of the run.
//   cfg_wr_en / cfg_wr_data write the operation (0 union, 1 intersection,
//   2 difference); write it only while the block is idle.
// timing:
//   set elements are taken one per cycle while the block is idle. a query
//   scans the A memory one address per cycle, then returns its found flag.
//   the last B element starts a compute run over all A elements and, for union,
//   all B elements too; each outer element is fetched, scanned against its own
//   earlier entries and the other set, then decided on.
//   input is not taken while a query or compute run is in progress.
// reset: synchronous active-low; counts clear, both sets start fresh, operation
//   returns to union, output valid clears.
// stall: a single output register holds each result; the sequencer waits on its
//   emit steps until the receiver takes the previous result.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module small_set_operation_engine import ssoe_pkg::*; #(
    parameter int SET_SIZE = SET_SIZE_DEF
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    // configuration write
    input  wire logic                     cfg_wr_en,
    input  wire logic [1:0]               cfg_wr_data,
    // input stream
    input  wire logic                     s_tvalid,
    output logic                          s_tready,
    input  wire logic signed [DATA_W-1:0] s_tdata,   // [31:0] value
    input  wire logic [1:0]               s_tuser,   // [1:0] kind
    input  wire logic                     s_tlast,   // last_of_set
    // result stream
    output logic                          m_tvalid,
    input  wire logic                     m_tready,
    output logic signed [DATA_W-1:0]      m_tdata,   // [31:0] element
    output logic [1:0]                    m_tuser,   // [0] is_empty, [1] found
    output logic                          m_tlast    // last
);

    localparam int CNT_W = $clog2(SET_SIZE + 1);
    localparam int IDX_W = (SET_SIZE > 1) ? $clog2(SET_SIZE) : 1;

    typedef enum logic [1:0] {
        PH_A,
        PH_B,
        PH_QUERY
    } phase_t;

    // set memories with registered read data
    logic signed [DATA_W-1:0] a_mem [SET_SIZE];
    logic signed [DATA_W-1:0] b_mem [SET_SIZE];
    logic signed [DATA_W-1:0] q_a_reg, q_b_reg;

    // sequencer and datapath registers
    step_t                    step_reg, step_next;
    logic [1:0]               oper_reg, oper_next;
    logic [CNT_W-1:0]         count_a_reg, count_a_next;
    logic [CNT_W-1:0]         count_b_reg, count_b_next;
    logic                     a_closed_reg, a_closed_next;
    logic                     b_closed_reg, b_closed_next;
    phase_t                   phase_reg, phase_next;
    logic [CNT_W-1:0]         i_reg, i_next;
    logic [IDX_W-1:0]         k_reg, k_next;
    logic signed [DATA_W-1:0] cur_reg, cur_next;
    logic                     hit_dup_reg, hit_dup_next;
    logic                     hit_oth_reg, hit_oth_next;
    logic                     pend_valid_reg, pend_valid_next;
    logic signed [DATA_W-1:0] pend_reg, pend_next;
    logic                     m_valid_reg, m_valid_next;
    logic signed [DATA_W-1:0] m_data_reg, m_data_next;
    logic                     m_empty_reg, m_empty_next;
    logic                     m_found_reg, m_found_next;
    logic                     m_last_reg, m_last_next;

    ctl_word_t                cw;
    logic                     in_acc, out_busy, hold, cond_ok, keep;
    logic                     emit, emit_empty, emit_found, emit_last;
    logic signed [DATA_W-1:0] emit_elem;
    logic [IDX_W-1:0]         rd_addr;
    logic                     a_we, b_we;
    logic [IDX_W-1:0]         a_waddr, b_waddr;
    logic                     a_room, b_room;
    logic signed [DATA_W-1:0] own_q, oth_q;
    logic [CNT_W-1:0]         outer_cnt, dup_lim, oth_lim, scan_end, k_ext, k_inc;
    logic                     b_last_acc;

    assign cw       = ucode_rom(step_reg);
    assign s_tready = (cw.uop == UOP_IDLE);
    assign in_acc   = s_tvalid && s_tready;
    assign out_busy = m_valid_reg && !m_tready;
    assign hold     = cw.stall && out_busy;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = {m_found_reg, m_empty_reg};
    assign m_tlast  = m_last_reg;

    // operand routing by phase
    assign own_q     = (phase_reg == PH_B) ? q_b_reg : q_a_reg;
    assign oth_q     = (phase_reg == PH_A) ? q_b_reg : q_a_reg;
    assign outer_cnt = (phase_reg == PH_B) ? count_b_reg : count_a_reg;
    assign oth_lim   = (phase_reg == PH_A) ? count_b_reg : count_a_reg;
    assign dup_lim   = (phase_reg == PH_QUERY) ? '0 : i_reg;
    assign scan_end  = (dup_lim > oth_lim) ? dup_lim : oth_lim;
    assign k_ext     = CNT_W'(k_reg);
    assign k_inc     = k_ext + 1'b1;

    // load side write control
    assign a_room  = count_a_reg < CNT_W'(SET_SIZE);
    assign b_room  = count_b_reg < CNT_W'(SET_SIZE);
    assign a_we    = in_acc && (s_tuser == KIND_A) && (a_closed_reg || a_room);
    assign b_we    = in_acc && (s_tuser == KIND_B) && (b_closed_reg || b_room);
    assign a_waddr = a_closed_reg ? '0 : count_a_reg[IDX_W-1:0];
    assign b_waddr = b_closed_reg ? '0 : count_b_reg[IDX_W-1:0];

    // last B element taken, starts a compute run
    assign b_last_acc = in_acc && (s_tuser == KIND_B) && s_tlast;

    // memory read address from the current step
    always_comb begin
        case (cw.uop)
            UOP_ISSUE: rd_addr = i_reg[IDX_W-1:0];
            UOP_SCAN:  rd_addr = k_reg + 1'b1;
            default:   rd_addr = '0;
        endcase
    end

    // keep decision for the element held in cur
    always_comb begin
        case (phase_reg)
            PH_A: begin
                case (oper_reg)
                    OPER_UNION: keep = !hit_dup_reg;
                    OPER_INTER: keep = !hit_dup_reg && hit_oth_reg;
                    OPER_DIFF:  keep = !hit_dup_reg && !hit_oth_reg;
                    default:    keep = 1'b0;
                endcase
            end
            PH_B:    keep = !hit_dup_reg && !hit_oth_reg;
            default: keep = 1'b0;
        endcase
    end

    // jump condition
    always_comb begin
        case (cw.cond)
            COND_NEVER:      cond_ok = 1'b0;
            COND_ALWAYS:     cond_ok = 1'b1;
            COND_OUTER_DONE: cond_ok = i_reg >= outer_cnt;
            COND_SCAN_MORE:  cond_ok = k_inc < scan_end;
            COND_IS_QUERY:   cond_ok = phase_reg == PH_QUERY;
            COND_TO_B:       cond_ok = (phase_reg == PH_A) && (oper_reg == OPER_UNION);
            default:         cond_ok = 1'b0;
        endcase
    end

    // next state of sequencer and datapath
    always_comb begin
        step_next       = step_reg;
        oper_next       = oper_reg;
        count_a_next    = count_a_reg;
        count_b_next    = count_b_reg;
        a_closed_next   = a_closed_reg;
        b_closed_next   = b_closed_reg;
        phase_next      = phase_reg;
        i_next          = i_reg;
        k_next          = k_reg;
        cur_next        = cur_reg;
        hit_dup_next    = hit_dup_reg;
        hit_oth_next    = hit_oth_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        emit            = 1'b0;
        emit_elem       = '0;
        emit_empty      = 1'b0;
        emit_found      = 1'b0;
        emit_last       = 1'b0;

        if (cfg_wr_en) begin
            oper_next = cfg_wr_data;
        end

        if (!hold) begin
            case (cw.uop)
                UOP_IDLE: begin
                    if (in_acc) begin
                        case (s_tuser)
                            KIND_A: begin
                                count_a_next  = a_closed_reg ? CNT_W'(1) :
                                                (a_room ? count_a_reg + 1'b1 : count_a_reg);
                                a_closed_next = s_tlast;
                            end
                            KIND_B: begin
                                count_b_next  = b_closed_reg ? CNT_W'(1) :
                                                (b_room ? count_b_reg + 1'b1 : count_b_reg);
                                b_closed_next = s_tlast;
                                if (s_tlast) begin
                                    step_next = ST_INIT;
                                end
                            end
                            KIND_QUERY: begin
                                cur_next   = s_tdata;
                                phase_next = PH_QUERY;
                                step_next  = ST_QSTART;
                            end
                            default: ;
                        endcase
                    end
                end
                UOP_INIT: begin
                    phase_next      = PH_A;
                    i_next          = '0;
                    pend_valid_next = 1'b0;
                end
                UOP_FETCH: begin
                    cur_next     = own_q;
                    k_next       = '0;
                    hit_dup_next = 1'b0;
                    hit_oth_next = 1'b0;
                end
                UOP_SCAN0: begin
                    k_next       = '0;
                    hit_dup_next = 1'b0;
                    hit_oth_next = 1'b0;
                end
                UOP_SCAN: begin
                    if ((k_ext < dup_lim) && (own_q == cur_reg)) begin
                        hit_dup_next = 1'b1;
                    end
                    if ((k_ext < oth_lim) && (oth_q == cur_reg)) begin
                        hit_oth_next = 1'b1;
                    end
                    k_next = k_reg + 1'b1;
                end
                UOP_DECIDE: begin
                    if (phase_reg == PH_QUERY) begin
                        emit       = 1'b1;
                        emit_found = hit_oth_reg;
                        emit_last  = 1'b1;
                    end else if (keep) begin
                        // the previous kept element is now known not to be last
                        if (pend_valid_reg) begin
                            emit      = 1'b1;
                            emit_elem = pend_reg;
                        end
                        pend_next       = cur_reg;
                        pend_valid_next = 1'b1;
                    end
                end
                UOP_NEXT: begin
                    i_next = i_reg + 1'b1;
                end
                UOP_ENDPASS: begin
                    if (cond_ok) begin
                        phase_next = PH_B;
                        i_next     = '0;
                    end
                end
                UOP_FLUSH: begin
                    emit       = 1'b1;
                    emit_last  = 1'b1;
                    emit_elem  = pend_valid_reg ? pend_reg : '0;
                    emit_empty = !pend_valid_reg;
                end
                default: ;
            endcase

            if (cw.uop != UOP_IDLE) begin
                step_next = cond_ok ? cw.target : step_reg + 1'b1;
            end
        end

        // output register
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        m_empty_next = m_empty_reg;
        m_found_next = m_found_reg;
        m_last_next  = m_last_reg;
        if (emit) begin
            m_valid_next = 1'b1;
            m_data_next  = emit_elem;
            m_empty_next = emit_empty;
            m_found_next = emit_found;
            m_last_next  = emit_last;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    // state and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg       <= ST_IDLE;
            oper_reg       <= OPER_UNION;
            count_a_reg    <= '0;
            count_b_reg    <= '0;
            a_closed_reg   <= 1'b1;
            b_closed_reg   <= 1'b1;
            phase_reg      <= PH_A;
            i_reg          <= '0;
            k_reg          <= '0;
            hit_dup_reg    <= 1'b0;
            hit_oth_reg    <= 1'b0;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            step_reg       <= step_next;
            oper_reg       <= oper_next;
            count_a_reg    <= count_a_next;
            count_b_reg    <= count_b_next;
            a_closed_reg   <= a_closed_next;
            b_closed_reg   <= b_closed_next;
            phase_reg      <= phase_next;
            i_reg          <= i_next;
            k_reg          <= k_next;
            hit_dup_reg    <= hit_dup_next;
            hit_oth_reg    <= hit_oth_next;
            pend_valid_reg <= pend_valid_next;
            m_valid_reg    <= m_valid_next;
        end
        cur_reg     <= cur_next;
        pend_reg    <= pend_next;
        m_data_reg  <= m_data_next;
        m_empty_reg <= m_empty_next;
        m_found_reg <= m_found_next;
        m_last_reg  <= m_last_next;
    end

    // set A memory
    always_ff @(posedge aclk) begin
        if (a_we) begin
            a_mem[a_waddr] <= s_tdata;
        end
        q_a_reg <= a_mem[rd_addr];
    end

    // set B memory
    always_ff @(posedge aclk) begin
        if (b_we) begin
            b_mem[b_waddr] <= s_tdata;
        end
        q_b_reg <= b_mem[rd_addr];
    end

    // checks
    `SSOE_ASSERT(a_count_bound, aclk, aresetn, count_a_reg <= CNT_W'(SET_SIZE), "count_a overflow")
    `SSOE_ASSERT(b_count_bound, aclk, aresetn, count_b_reg <= CNT_W'(SET_SIZE), "count_b overflow")
    `SSOE_ASSERT(no_overwrite, aclk, aresetn, !(emit && out_busy), "result overwritten")
    `SSOE_ASSERT(step_in_program, aclk, aresetn, step_reg <= ST_LAST, "step outside program")
    `SSOE_ASSERT_NEXT(b_last_go, aclk, aresetn, b_last_acc, step_reg == ST_INIT, "no compute start")

endmodule

`default_nettype wire

### test/tb.sv
`timescale 1ns / 1ps
// self-checking testbench for small_set_operation_engine: directed table, then random rounds
// depends on ssoe_pkg and the engine rtl; results are checked against a set predictor or the table's typed values

module tb import ssoe_pkg::*; ();

    localparam int         SET_SZ      = SET_SIZE_DEF;
    localparam int         CYCLE_CAP   = 1_000_000;
    localparam int         PHASE_ITEMS = 32;
    localparam int         N_DIR       = 25;
    localparam logic [1:0] KIND_NONE   = 2'd3;   // unused kind, ignored by the block
    localparam logic [1:0] OPER_NONE   = 2'd3;   // unused operation, always an empty result

    typedef struct packed {
        logic signed [31:0] element;
        logic               is_empty;
        logic               found;
        logic               last;
    } result_t;

    // how a directed row is checked: no result, result typed in the row, or predictor
    typedef enum logic [1:0] { CHK_NONE, CHK_TYPED, CHK_MODEL } row_chk_t;

    typedef struct packed {
        logic [1:0]  oper;
        logic [1:0]  kind;
        logic [31:0] value;
        logic        last;
        int          rep;
        row_chk_t    chk;
        logic [31:0] element;
        logic        is_empty;
        logic        found;
    } dir_row_t;

    logic               aclk        = 1'b0;
    logic               aresetn     = 1'b0;
    logic               cfg_wr_en   = 1'b0;
    logic [1:0]         cfg_wr_data = 2'd0;
    logic               s_tvalid    = 1'b0;
    logic               s_tready;
    logic signed [31:0] s_tdata     = '0;
    logic [1:0]         s_tuser     = 2'd0;
    logic               s_tlast     = 1'b0;
    logic               m_tvalid;
    logic               m_tready    = 1'b0;
    logic signed [31:0] m_tdata;
    logic [1:0]         m_tuser;
    logic               m_tlast;

    // predictor state: shadow copies of both set memories and their counts
    logic [31:0] shadow_a [SET_SZ];
    logic [31:0] shadow_b [SET_SZ];
    int unsigned cnt_a    = 0;
    int unsigned cnt_b    = 0;
    bit          a_done   = 1'b1;
    bit          b_done   = 1'b1;
    logic [1:0]  cur_oper = OPER_UNION;

    result_t     run_items[$];       // results caused by the transaction just taken
    result_t     awaited_items[$];   // results still owed by the engine, oldest first
    result_t     head;
    logic [31:0] val_pool [6];
    dir_row_t    dir_rows [N_DIR];
    logic [1:0]  phase_oper [8];

    int src_idle_pct   = 0;
    int sink_stall_pct = 0;
    int err_count      = 0;
    int cycle_count    = 0;
    int sent_items     = 0;

    small_set_operation_engine #(
        .SET_SIZE(SET_SZ)
    ) u_dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .s_tlast    (s_tlast),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

    always #4 aclk = ~aclk;

    function automatic result_t make_result(input logic [31:0] elem, input logic empty,
                                            input logic hit, input logic fin);
        result_t r;
        r.element  = elem;
        r.is_empty = empty;
        r.found    = hit;
        r.last     = fin;
        return r;
    endfunction

    // membership in the first upto entries of one shadow set
    function automatic bit held_in(input bit in_b, input int unsigned upto,
                                   input logic [31:0] v);
        for (int unsigned i = 0; i < upto; i++) begin
            if ((in_b ? shadow_b[i] : shadow_a[i]) == v)
                return 1'b1;
        end
        return 1'b0;
    endfunction

    // a closed set restarts on its next element; overflow elements are dropped
    function automatic void store_elem(input bit in_b, input logic [31:0] v, input bit fin);
        if (!in_b) begin
            if (a_done) begin
                cnt_a  = 0;
                a_done = 1'b0;
            end
            if (cnt_a < SET_SZ) begin
                shadow_a[cnt_a] = v;
                cnt_a++;
            end
            if (fin)
                a_done = 1'b1;
        end else begin
            if (b_done) begin
                cnt_b  = 0;
                b_done = 1'b0;
            end
            if (cnt_b < SET_SZ) begin
                shadow_b[cnt_b] = v;
                cnt_b++;
            end
            if (fin)
                b_done = 1'b1;
        end
    endfunction

    // union / intersection / difference in A order, then B order for union; duplicates skipped
    function automatic void compute_result_set();
        logic [31:0] v;
        bit          in_b;
        result_t     tail;
        if (cur_oper == OPER_UNION || cur_oper == OPER_INTER || cur_oper == OPER_DIFF) begin
            for (int unsigned i = 0; i < cnt_a; i++) begin
                v    = shadow_a[i];
                in_b = held_in(1'b1, cnt_b, v);
                if (held_in(1'b0, i, v))
                    continue;
                if ((cur_oper == OPER_INTER && !in_b) || (cur_oper == OPER_DIFF && in_b))
                    continue;
                run_items.push_back(make_result(v, 1'b0, 1'b0, 1'b0));
            end
            if (cur_oper == OPER_UNION) begin
                for (int unsigned i = 0; i < cnt_b; i++) begin
                    v = shadow_b[i];
                    if (held_in(1'b0, cnt_a, v) || held_in(1'b1, i, v))
                        continue;
                    run_items.push_back(make_result(v, 1'b0, 1'b0, 1'b0));
                end
            end
        end
        if (run_items.size() == 0) begin
            run_items.push_back(make_result('0, 1'b1, 1'b0, 1'b1));
        end else begin
            tail      = run_items.pop_back();
            tail.last = 1'b1;
            run_items.push_back(tail);
        end
    endfunction

    // update shadow state for one taken transaction and collect its results
    function automatic void apply_item(input logic [1:0] kind, input logic [31:0] v,
                                       input logic fin);
        run_items.delete();
        case (kind)
            KIND_A: store_elem(1'b0, v, fin);
            KIND_B: begin
                store_elem(1'b1, v, fin);
                if (fin)
                    compute_result_set();
            end
            KIND_QUERY: run_items.push_back(make_result('0, 1'b0, held_in(1'b0, cnt_a, v), 1'b1));
            default: ;
        endcase
    endfunction

    // drive one input transaction with random gaps ahead of it
    task automatic send_item(input logic [1:0] kind, input logic [31:0] v, input logic fin);
        if ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < src_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= v;
        s_tlast  <= fin;
        do @(posedge aclk); while (!s_tready);
        apply_item(kind, v, fin);
        sent_items++;
    endtask

    task automatic send_pred(input logic [1:0] kind, input logic [31:0] v, input logic fin);
        send_item(kind, v, fin);
        foreach (run_items[i])
            awaited_items.push_back(run_items[i]);
    endtask

    // stop sending and wait until every owed result has come back
    task automatic drain_results();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (awaited_items.size() != 0);
    endtask

    task automatic set_operation(input logic [1:0] op);
        drain_results();
        // a trailing set load may still be settling
        repeat (32) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= op;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        cur_oper = op;
    endtask

    // small value pool per round so that sets overlap and repeat
    task automatic fill_pool();
        for (int i = 0; i < 6; i++) begin
            case ($urandom_range(7))
                0:       val_pool[i] = 32'h8000_0000;
                1:       val_pool[i] = 32'h7fff_ffff;
                2:       val_pool[i] = 32'h0000_0000;
                3:       val_pool[i] = 32'hffff_ffff;
                default: val_pool[i] = $urandom;
            endcase
        end
    endtask

    function automatic logic [31:0] pick_value();
        if ($urandom_range(9) < 7)
            return val_pool[$urandom_range(5)];
        return $urandom;
    endfunction

    // mostly small sets, now and then one near or past the store depth
    function automatic int set_size();
        if ($urandom_range(7) == 0)
            return $urandom_range(SET_SZ + 4, SET_SZ - 2);
        return $urandom_range(6, 1);
    endfunction

    task automatic send_set(input logic [1:0] kind, input int n, input int query_pct);
        for (int i = 0; i < n; i++) begin
            send_pred(kind, pick_value(), i == n - 1);
            if ($urandom_range(99) < query_pct)
                send_pred(KIND_QUERY, pick_value(), 1'($urandom_range(1)));
        end
    endtask

    // one round: usually a well-formed A set then B set, sometimes loose noise
    task automatic run_round();
        int unsigned sel;
        sel = $urandom_range(9);
        fill_pool();
        if (sel == 0) begin
            repeat ($urandom_range(3, 1))
                send_pred(2'($urandom_range(3)), $urandom, 1'($urandom_range(1)));
        end else begin
            // one round in ten keeps the previous A set
            if (sel != 1)
                send_set(KIND_A, set_size(), 15);
            send_set(KIND_B, set_size(), 10);
        end
    endtask

    // receiver stall pattern
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // result checker: each result transaction against the oldest owed result
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (awaited_items.size() == 0) begin
                err_count++;
                if (err_count <= 40)
                    $display("%0t: unexpected result, expected none,", $time,
                             " actual element=%0d empty=%b found=%b last=%b",
                             m_tdata, m_tuser[0], m_tuser[1], m_tlast);
            end else begin
                head = awaited_items.pop_front();
                if (m_tdata !== head.element || m_tuser[0] !== head.is_empty ||
                    m_tuser[1] !== head.found || m_tlast !== head.last) begin
                    err_count++;
                    if (err_count <= 40)
                        $display("%0t: mismatch, expected element=%0d empty=%b found=%b last=%b,",
                                 $time, head.element, head.is_empty, head.found, head.last,
                                 " actual element=%0d empty=%b found=%b last=%b",
                                 m_tdata, m_tuser[0], m_tuser[1], m_tlast);
                end
            end
        end
    end

    // run limit
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_CAP) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        dir_row_t row;
        logic     fin;
        int       target;
        bit       paused;

        dir_rows = '{
            // query against the empty A set after reset
            '{OPER_UNION, KIND_QUERY, 32'd0,         1'b0, 1,  CHK_TYPED, 32'd0, 1'b0, 1'b0},
            // union with nothing in A gives B alone
            '{OPER_UNION, KIND_B,     32'd5,         1'b1, 1,  CHK_MODEL, 32'd0, 1'b0, 1'b0},
            // A set of extremes with a repeated element
            '{OPER_UNION, KIND_A,     32'h8000_0000, 1'b0, 1,  CHK_NONE,  32'd0, 1'b0, 1'b0},
            '{OPER_UNION, KIND_A,     32'h7fff_ffff, 1'b0, 1,  CHK_NONE,  32'd0, 1'b0, 1'b0},
            '{OPER_UNION, KIND_A,     32'hffff_ffff, 1'b0, 1,  CHK_NONE,  32'd0, 1'b0, 1'b0},
            '{OPER_UNION, KIND_A,     32'h7fff_ffff, 1'b1, 1,  CHK_NONE,  32'd0, 1'b0, 1'b0},
            '{OPER_UNION, KIND_QUERY, 32'h8000_0000, 1'b0, 1,  CHK_TYPED, 32'd0, 1'b0, 1'b1},
            '{OPER_UNION, KIND_QUERY, 32'd1,         1'b0, 1,  CHK_TYPED, 32'd0, 1'b0, 1'b0},
            // unused kind is dropped
            '{OPER_UNION, KIND_NONE,  32'h7fff_ffff, 1'b1, 1,  CHK_NONE,  32'd0, 1'b0, 1'b0},
            // B with a duplicate, union over both
            '{OPER_UNION, KIND_B,     32'hffff_ffff, 1'b0, 1,  CHK_NONE,  32'd0, 1'b0, 1'b0},
            '{OPER_UNION, KIND_B,     32'd7,         1'b0, 1,  CHK_NONE,  32'd0, 1'b0, 1'b0},
            '{OPER_UNION, KIND_B,     32'd7,         1'b1, 1,  CHK_MODEL, 32'd0, 1'b0, 1'b0},
            // intersection, then an empty intersection
            '{OPER_INTER, KIND_B,     32'h8000_0000, 1'b1, 1,  CHK_MODEL, 32'd0, 1'b0, 1'b0},
            '{OPER_INTER, KIND_B,     32'd3,         1'b1, 1,  CHK_TYPED, 32'd0, 1'b1, 1'b0},
            // difference, then an empty difference
            '{OPER_DIFF,  KIND_B,     32'h8000_0000, 1'b1, 1,  CHK_MODEL, 32'd0, 1'b0, 1'b0},
            '{OPER_DIFF,  KIND_A,     32'd9,         1'b1, 1,  CHK_NONE,  32'd0, 1'b0, 1'b0},
            '{OPER_DIFF,  KIND_B,     32'd9,         1'b1, 1,  CHK_TYPED, 32'd0, 1'b1, 1'b0},
            // unused operation code gives the empty result
            '{OPER_NONE,  KIND_B,     32'd4,         1'b1, 1,  CHK_TYPED, 32'd0, 1'b1, 1'b0},
            // oversized A set: the element past the depth is dropped
            '{OPER_UNION, KIND_A,     32'd100,       1'b1, 17, CHK_NONE,  32'd0, 1'b0, 1'b0},
            '{OPER_UNION, KIND_QUERY, 32'd116,       1'b0, 1,  CHK_TYPED, 32'd0, 1'b0, 1'b0},
            '{OPER_UNION, KIND_QUERY, 32'd115,       1'b0, 1,  CHK_TYPED, 32'd0, 1'b0, 1'b1},
            // query sees A while it is still open
            '{OPER_UNION, KIND_A,     32'd200,       1'b0, 1,  CHK_NONE,  32'd0, 1'b0, 1'b0},
            '{OPER_UNION, KIND_QUERY, 32'd200,       1'b1, 1,  CHK_TYPED, 32'd0, 1'b0, 1'b1},
            '{OPER_UNION, KIND_A,     32'd201,       1'b1, 1,  CHK_NONE,  32'd0, 1'b0, 1'b0},
            '{OPER_UNION, KIND_B,     32'd200,       1'b1, 1,  CHK_MODEL, 32'd0, 1'b0, 1'b0}
        };
        phase_oper = '{OPER_UNION, OPER_INTER, OPER_DIFF, OPER_UNION,
                       OPER_DIFF, OPER_INTER, OPER_NONE, OPER_UNION};

        // reset
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed table
        for (int r = 0; r < N_DIR; r++) begin
            row = dir_rows[r];
            if (row.oper != cur_oper)
                set_operation(row.oper);
            for (int i = 0; i < row.rep; i++) begin
                fin = row.last && (i == row.rep - 1);
                send_item(row.kind, row.value + i, fin);
                if (i == row.rep - 1) begin
                    case (row.chk)
                        CHK_TYPED: awaited_items.push_back(make_result(row.element, row.is_empty,
                                                                       row.found, 1'b1));
                        CHK_MODEL: begin
                            foreach (run_items[k])
                                awaited_items.push_back(run_items[k]);
                        end
                        default: ;
                    endcase
                end
            end
        end

        // random phases over operations and idle patterns
        paused = 1'b0;
        for (int ph = 0; ph < 8; ph++) begin
            case (ph % 4)
                0: begin
                    src_idle_pct   = 0;
                    sink_stall_pct = 0;
                end
                1: begin
                    src_idle_pct   = 87;
                    sink_stall_pct = 0;
                end
                2: begin
                    src_idle_pct   = 0;
                    sink_stall_pct = 87;
                end
                default: begin
                    src_idle_pct   = 23;
                    sink_stall_pct = 23;
                end
            endcase
            set_operation(phase_oper[ph]);
            target = sent_items + PHASE_ITEMS;
            while (sent_items < target) begin
                run_round();
                // sender holds off mid-phase until the engine has caught up
                if (ph == 2 && !paused && sent_items >= target - PHASE_ITEMS / 2) begin
                    drain_results();
                    paused = 1'b1;
                end
            end
        end

        // wind down
        drain_results();
        repeat (200) @(posedge aclk);
        if (err_count == 0 && awaited_items.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

### sim.f
+incdir+rtl/core
rtl/core/ssoe_pkg.sv
rtl/core/small_set_operation_engine.sv
test/tb.sv
